// ===== hw/rtl/aflm_pkg.sv =====
// ----------------------------------------------------------------------------
// aflm_pkg
// Shared widths, register indexes and controller/datapath command types for
// the audio frame level meter.
// ----------------------------------------------------------------------------
package aflm_pkg;

	localparam int unsigned MAX_FRAME_SAMPLES_DEF = 65536;

	localparam int unsigned SAMPLE_W    = 32;
	localparam int unsigned PEAK_W      = 32;
	localparam int unsigned RMS_W       = 40;
	localparam int unsigned FRAME_W     = 17;
	localparam int unsigned SUM_W       = 64;
	localparam int unsigned WIDTH_CFG_W = 3;
	localparam int unsigned THR_W       = 32;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned CFG_DATA_W  = 32;

	// sum * 65536 / count, then an integer root of that quotient
	localparam int unsigned FRAC_SHIFT  = 16;
	localparam int unsigned NUM_W       = SUM_W + FRAC_SHIFT;
	localparam int unsigned ROOT_W      = NUM_W / 2;
	localparam int unsigned RREM_W      = ROOT_W + 2;
	localparam int unsigned DIV_STEPS   = NUM_W;
	localparam int unsigned ROOT_STEPS  = ROOT_W;
	localparam int unsigned STEP_W      = $clog2(DIV_STEPS);

	localparam logic [WIDTH_CFG_W-1:0] WIDTH_RESET = 3'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VAD_THRESHOLD = 2'd1;

	typedef struct packed {
		logic take_sample;
		logic div_load;
		logic div_step;
		logic root_step;
		logic out_load;
	} aflm_cmd_t;

	typedef struct packed {
		logic pipe_empty;
		logic out_busy;
	} aflm_stat_t;

endpackage

// ===== hw/rtl/aflm_sample_if.sv =====
// ----------------------------------------------------------------------------
// aflm_sample_if
// Sample stream channel: raw little-endian bytes and end-of-frame mark.
// ----------------------------------------------------------------------------
interface aflm_sample_if;
	logic                          valid;
	logic                          ready;
	logic [aflm_pkg::SAMPLE_W-1:0] sample_bytes;
	logic                          last_sample;

	modport source (output valid, output sample_bytes, output last_sample, input ready);
	modport sink (input valid, input sample_bytes, input last_sample, output ready);
endinterface

// ===== hw/rtl/aflm_result_if.sv =====
// ----------------------------------------------------------------------------
// aflm_result_if
// Per-frame result channel: peak, RMS, voice activity, count and overflow.
// ----------------------------------------------------------------------------
interface aflm_result_if;
	logic                         valid;
	logic                         ready;
	logic [aflm_pkg::PEAK_W-1:0]  peak_level;
	logic [aflm_pkg::RMS_W-1:0]   rms_level;
	logic                         voice_active;
	logic [aflm_pkg::FRAME_W-1:0] frame_samples;
	logic                         level_overflow;

	modport source (output valid, output peak_level, output rms_level, output voice_active,
		output frame_samples, output level_overflow, input ready);
	modport sink (input valid, input peak_level, input rms_level, input voice_active,
		input frame_samples, input level_overflow, output ready);
endinterface

// ===== hw/rtl/aflm_cfg_if.sv =====
// ----------------------------------------------------------------------------
// aflm_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface aflm_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [aflm_pkg::CFG_IDX_W-1:0]  index;
	logic [aflm_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/aflm_ctrl.sv =====
// ----------------------------------------------------------------------------
// aflm_ctrl
// Frame sequencer: accepts samples, drains the square/accumulate pipeline at
// frame end, steps the shared divide and root unit, then loads the result.
// ----------------------------------------------------------------------------
module aflm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	input  logic                  sample_last,
	output logic                  sample_ready,
	input  aflm_pkg::aflm_stat_t  stat,
	output aflm_pkg::aflm_cmd_t   cmd
);

	localparam logic [2:0] ST_ACC   = 3'd0;
	localparam logic [2:0] ST_DRAIN = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_ROOT  = 3'd3;
	localparam logic [2:0] ST_WOUT  = 3'd4;

	localparam logic [aflm_pkg::STEP_W-1:0] DIV_LAST  =
		aflm_pkg::STEP_W'(aflm_pkg::DIV_STEPS - 1);
	localparam logic [aflm_pkg::STEP_W-1:0] ROOT_LAST =
		aflm_pkg::STEP_W'(aflm_pkg::ROOT_STEPS - 1);

	logic [2:0]                  state_q;
	logic [2:0]                  state_d;
	logic [aflm_pkg::STEP_W-1:0] step_q;
	logic [aflm_pkg::STEP_W-1:0] step_d;

	assign sample_ready = (state_q == ST_ACC);

	always_comb begin
		state_d         = state_q;
		step_d          = step_q;
		cmd             = '0;
		case (state_q)
			ST_ACC: begin
				cmd.take_sample = sample_valid;
				if (sample_valid && sample_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (stat.pipe_empty) begin
					cmd.div_load = 1'b1;
					step_d       = DIV_LAST;
					state_d      = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == '0) begin
					step_d  = ROOT_LAST;
					state_d = ST_ROOT;
				end else begin
					step_d = step_q - 1'b1;
				end
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				if (step_q == '0) begin
					state_d = ST_WOUT;
				end else begin
					step_d = step_q - 1'b1;
				end
			end
			ST_WOUT: begin
				// hold until the previous result has been taken
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_ACC;
				end
			end
			default: begin
				state_d = ST_ACC;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

endmodule

// ===== hw/rtl/aflm_dp.sv =====
// ----------------------------------------------------------------------------
// aflm_dp
// Datapath: configuration registers, magnitude/square/accumulate pipeline,
// bit-serial divider and digit-by-digit square root, and result register.
// ----------------------------------------------------------------------------
module aflm_dp #(
	parameter int unsigned MAX_FRAME_SAMPLES = aflm_pkg::MAX_FRAME_SAMPLES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  aflm_pkg::aflm_cmd_t           cmd,
	output aflm_pkg::aflm_stat_t          stat,
	input  logic [aflm_pkg::SAMPLE_W-1:0] sample_bytes,
	aflm_cfg_if.sink                      cfg,
	aflm_result_if.source                 result
);

	localparam int unsigned CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_SAMPLES);

	localparam int unsigned NUM_W  = aflm_pkg::NUM_W;
	localparam int unsigned ROOT_W = aflm_pkg::ROOT_W;
	localparam int unsigned RREM_W = aflm_pkg::RREM_W;

	// configuration
	logic [aflm_pkg::WIDTH_CFG_W-1:0] width_q;
	logic [aflm_pkg::THR_W-1:0]       thr_q;

	// sample pipeline and frame state
	logic                         v_s1;
	logic                         v_s2;
	logic [aflm_pkg::PEAK_W-1:0]  mag_s1;
	logic [aflm_pkg::SUM_W-1:0]   sq_s2;
	logic [aflm_pkg::PEAK_W-1:0]  peak_q;
	logic [aflm_pkg::SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]             count_q;
	logic                         ovf_q;

	// shared divide/root unit
	logic [NUM_W-1:0]  x_q;
	logic [CNT_W-1:0]  rem_q;
	logic [RREM_W-1:0] rrem_q;
	logic [ROOT_W-1:0] root_q;

	logic                         out_valid_q;
	logic [aflm_pkg::SAMPLE_W-1:0] sext;
	logic [aflm_pkg::PEAK_W-1:0]  mag;
	logic [aflm_pkg::SUM_W:0]     sum_next;
	logic [CNT_W:0]               div_trial;
	logic [CNT_W:0]               div_diff;
	logic                         div_ge;
	logic [RREM_W+1:0]            root_trial;
	logic [RREM_W+1:0]            root_sub;
	logic [RREM_W+1:0]            root_diff;
	logic                         root_ge;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= aflm_pkg::WIDTH_RESET;
			thr_q   <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				aflm_pkg::REG_SAMPLE_WIDTH:  width_q <= cfg.data[aflm_pkg::WIDTH_CFG_W-1:0];
				aflm_pkg::REG_VAD_THRESHOLD: thr_q   <= cfg.data[aflm_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	// sign-extend from the configured width; zero acts as one byte, above four as four
	always_comb begin
		case (width_q)
			3'd0, 3'd1: sext = {{24{sample_bytes[7]}}, sample_bytes[7:0]};
			3'd2:       sext = {{16{sample_bytes[15]}}, sample_bytes[15:0]};
			3'd3:       sext = {{8{sample_bytes[23]}}, sample_bytes[23:0]};
			default:    sext = sample_bytes;
		endcase
		// the most negative 32-bit value wraps to 2^31, which is the wanted magnitude
		mag = sext[aflm_pkg::SAMPLE_W-1] ? (~sext + 32'd1) : sext;
	end

	assign sum_next = {1'b0, sum_q} + {1'b0, sq_s2};

	assign stat.pipe_empty = !v_s1 && !v_s2;
	assign stat.out_busy   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			peak_q  <= '0;
			sum_q   <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.out_load) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			peak_q  <= '0;
			sum_q   <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			v_s1 <= 1'b0;
			v_s2 <= v_s1;
			if (cmd.take_sample) begin
				// drop samples past the frame limit
				if (count_q >= CNT_MAX) begin
					ovf_q <= 1'b1;
				end else begin
					v_s1    <= 1'b1;
					count_q <= count_q + 1'b1;
				end
			end
			if (v_s1 && (mag_s1 > peak_q)) begin
				peak_q <= mag_s1;
			end
			if (v_s2) begin
				if (sum_next[aflm_pkg::SUM_W]) begin
					sum_q <= '1;
					ovf_q <= 1'b1;
				end else begin
					sum_q <= sum_next[aflm_pkg::SUM_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		mag_s1 <= mag;
		sq_s2  <= aflm_pkg::SUM_W'(mag_s1) * aflm_pkg::SUM_W'(mag_s1);
	end

	// restoring division, one quotient bit a cycle; quotient shifts into x_q
	assign div_trial = {rem_q, x_q[NUM_W-1]};
	assign div_diff  = div_trial - {1'b0, count_q};
	assign div_ge    = (div_trial >= {1'b0, count_q});

	// integer square root, two radicand bits a cycle
	assign root_trial = {rrem_q, x_q[NUM_W-1:NUM_W-2]};
	assign root_sub   = {2'b00, root_q, 2'b01};
	assign root_diff  = root_trial - root_sub;
	assign root_ge    = (root_trial >= root_sub);

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			x_q    <= {sum_q, {aflm_pkg::FRAC_SHIFT{1'b0}}};
			rem_q  <= '0;
			rrem_q <= '0;
			root_q <= '0;
		end else if (cmd.div_step) begin
			x_q   <= {x_q[NUM_W-2:0], div_ge};
			rem_q <= div_ge ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
		end else if (cmd.root_step) begin
			x_q    <= {x_q[NUM_W-3:0], 2'b00};
			rrem_q <= root_ge ? root_diff[RREM_W-1:0] : root_trial[RREM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], root_ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result.peak_level     <= peak_q;
			result.rms_level      <= (count_q == '0) ? '0 : aflm_pkg::RMS_W'(root_q);
			result.voice_active   <= (peak_q >= thr_q);
			result.frame_samples  <= aflm_pkg::FRAME_W'(count_q);
			result.level_overflow <= ovf_q;
		end
	end

	assign result.valid = out_valid_q;

endmodule

// ===== hw/rtl/audio_frame_level_meter_core.sv =====
// ----------------------------------------------------------------------------
// audio_frame_level_meter_core
// Within a frame one sample is taken every cycle (magnitude, square, add).
// After the last sample of a frame the input stalls: the square/accumulate
// pipeline drains and the divider loads, the bit-serial divider and then the
// square root run, and the result register loads, which is valid on the
// following cycle. The stall lasts longer while the previous result waits.
// arst_n clears frame state and result valid; sample width resets to 2 bytes
// and the voice threshold to 0.
// ----------------------------------------------------------------------------
module audio_frame_level_meter_core #(
	parameter int unsigned MAX_FRAME_SAMPLES = aflm_pkg::MAX_FRAME_SAMPLES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	aflm_sample_if.sink   sample,
	aflm_result_if.source result,
	aflm_cfg_if.sink      cfg
);

	aflm_pkg::aflm_cmd_t  cmd;
	aflm_pkg::aflm_stat_t stat;
	logic                 ready;

	assign sample.ready = ready;

	aflm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample.valid),
		.sample_last  (sample.last_sample),
		.sample_ready (ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	aflm_dp #(
		.MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.sample_bytes (sample.sample_bytes),
		.cfg          (cfg),
		.result       (result)
	);

endmodule

// ===== test/tb_audio_frame_level_meter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_frame_level_meter_core
// Streams PCM samples into the level meter across several width and voice
// threshold settings, predicts each frame's peak, RMS, activity and overflow
// in a scoreboard and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module tb_audio_frame_level_meter_core;
	import aflm_pkg::*;

	typedef struct packed {
		logic [PEAK_W-1:0]  peak;
		logic [RMS_W-1:0]   rms;
		logic               voice;
		logic [FRAME_W-1:0] count;
		logic               overflow;
	} frame_result_t;

	class level_meter_scoreboard;
		logic [WIDTH_CFG_W-1:0] width_cfg = WIDTH_RESET;
		logic [THR_W-1:0]       threshold = '0;
		logic [PEAK_W-1:0]      peak = '0;
		logic [SUM_W-1:0]       sum_sq = '0;
		logic [FRAME_W-1:0]     count = '0;
		logic                   overflow = 1'b0;
		frame_result_t          pending[$];
		int                     errors = 0;

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			if (idx == REG_SAMPLE_WIDTH)
				width_cfg = value[WIDTH_CFG_W-1:0];
			else if (idx == REG_VAD_THRESHOLD)
				threshold = value;
		endfunction

		function int sample_bytes_used();
			if (width_cfg == 0)
				return 1;
			if (width_cfg > 4)
				return 4;
			return int'(width_cfg);
		endfunction

		// floor(sqrt(sum * 65536 / count)), one root bit per pass
		function logic [RMS_W-1:0] frame_root(logic [SUM_W-1:0] s, logic [FRAME_W-1:0] n);
			logic [NUM_W-1:0]  quot;
			logic [NUM_W-1:0]  square;
			logic [RMS_W-1:0]  root;
			logic [RMS_W-1:0]  cand;
			if (n == 0)
				return '0;
			quot = {s, 16'h0000} / n;
			root = '0;
			for (int b = RMS_W - 1; b >= 0; b--) begin
				cand = root | (40'd1 << b);
				square = NUM_W'(cand) * NUM_W'(cand);
				if (square <= quot)
					root = cand;
			end
			return root;
		endfunction

		function void note_sample(logic [SAMPLE_W-1:0] raw, logic last);
			logic [63:0] mask;
			logic [63:0] val;
			logic [63:0] mag;
			logic [63:0] sq;
			logic [64:0] acc;
			int          bits;
			bits = 8 * sample_bytes_used();
			if (count >= MAX_FRAME_SAMPLES_DEF) begin
				overflow = 1'b1;
			end else begin
				mask = (64'd1 << bits) - 64'd1;
				val = {32'd0, raw} & mask;
				if (val[bits-1])
					mag = (64'd1 << bits) - val;
				else
					mag = val;
				if (mag[31:0] > peak)
					peak = mag[31:0];
				sq = mag * mag;
				acc = {1'b0, sum_sq} + {1'b0, sq};
				if (acc[64]) begin
					sum_sq = '1;
					overflow = 1'b1;
				end else begin
					sum_sq = acc[63:0];
				end
				count = count + 1'b1;
			end
			if (last) begin
				pending.push_back('{peak, frame_root(sum_sq, count), peak >= threshold,
					count, overflow});
				peak = '0;
				sum_sq = '0;
				count = '0;
				overflow = 1'b0;
			end
		endfunction

		function int outstanding();
			return pending.size();
		endfunction

		task report_mismatch(string what);
			$display("MISMATCH at %0t: %s", $realtime, what);
			errors++;
		endtask

		task check_result(frame_result_t got);
			frame_result_t want;
			if (pending.size() == 0) begin
				report_mismatch("result transfer with no frame pending");
				return;
			end
			want = pending.pop_front();
			if (got.peak !== want.peak)
				report_mismatch($sformatf("peak_level %0h, predicted %0h", got.peak, want.peak));
			if (got.rms !== want.rms)
				report_mismatch($sformatf("rms_level %0h, predicted %0h", got.rms, want.rms));
			if (got.voice !== want.voice)
				report_mismatch($sformatf("voice_active %0b, predicted %0b", got.voice,
					want.voice));
			if (got.count !== want.count)
				report_mismatch($sformatf("frame_samples %0d, predicted %0d", got.count,
					want.count));
			if (got.overflow !== want.overflow)
				report_mismatch($sformatf("level_overflow %0b, predicted %0b", got.overflow,
					want.overflow));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic hold_ready = 1'b0;
	int   stall_left = 0;
	bit   idle_on = 1'b1;
	bit   pressure_done = 1'b0;

	level_meter_scoreboard meter_sb = new;
	frame_result_t         seen;

	aflm_sample_if sample_ch();
	aflm_result_if result_ch();
	aflm_cfg_if    cfg_ch();

	audio_frame_level_meter_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#36_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int gap_cycles();
		int pick;
		pick = $urandom_range(0, 99);
		if (!idle_on || pick < 65)
			return 0;
		if (pick < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int frame_length();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			return $urandom_range(1, 4);
		if (pick < 85)
			return $urandom_range(5, 24);
		return $urandom_range(25, 120);
	endfunction

	// bias towards the extremes of the configured width, upper bytes left as noise
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		logic [63:0] mask;
		logic [31:0] noise;
		logic [31:0] low;
		noise = $urandom();
		mask = (64'd1 << (8 * meter_sb.sample_bytes_used())) - 64'd1;
		low = mask[31:0];
		case ($urandom_range(0, 9))
			0: return (noise & ~low) | (low ^ (low >> 1));
			1: return (noise & ~low) | (low >> 1);
			2: return noise & ~low;
			3: return noise | low;
			4: return (noise & ~low) | $urandom_range(0, 15);
			5: return (noise & ~low) | ((low - $urandom_range(0, 15)) & low);
			default: return noise;
		endcase
	endfunction

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			hold_ready <= 1'b0;
		end else begin
			stall_left <= gap_cycles();
			hold_ready <= 1'b1;
		end
	end

	assign result_ch.ready = hold_ready;

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			seen.peak = result_ch.peak_level;
			seen.rms = result_ch.rms_level;
			seen.voice = result_ch.voice_active;
			seen.count = result_ch.frame_samples;
			seen.overflow = result_ch.level_overflow;
			meter_sb.check_result(seen);
		end
	end

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		meter_sb.write_register(idx, value);
	endtask

	// valid stays high across back-to-back transfers; it only drops for a gap
	task automatic send_sample(logic [SAMPLE_W-1:0] raw, logic last, int gap);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.sample_bytes <= raw;
		sample_ch.last_sample <= last;
		do @(posedge clk); while (!sample_ch.ready);
		meter_sb.note_sample(raw, last);
	endtask

	task automatic settle();
		while (meter_sb.outstanding() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic run_random_phase(int budget);
		int sent;
		int len;
		sent = 0;
		while (sent < budget) begin
			len = frame_length();
			for (int i = 0; i < len; i++)
				send_sample(pick_sample(), i == len - 1, gap_cycles());
			sent += len;
			// first frame, then about one in twenty: hold until every frame result is taken
			if (!pressure_done || $urandom_range(0, 19) == 0) begin
				pressure_done = 1'b1;
				sample_ch.valid <= 1'b0;
				while (meter_sb.outstanding() != 0)
					@(posedge clk);
			end
		end
		sample_ch.valid <= 1'b0;
		settle();
	endtask

	initial begin
		int widths[8];
		int bits;
		logic [THR_W-1:0] thr;
		widths = '{4, 1, 2, 3, 0, 5, 6, 7};
		sample_ch.valid = 1'b0;
		sample_ch.sample_bytes = '0;
		sample_ch.last_sample = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_SAMPLE_WIDTH;
		cfg_ch.data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		// reset settings: 16-bit samples, upper bytes must be ignored
		send_sample(32'h0000_8000, 1'b1, gap_cycles());
		send_sample(32'hABCD_7FFF, 1'b0, gap_cycles());
		send_sample(32'h1234_0000, 1'b0, gap_cycles());
		send_sample(32'hFFFF_FFFF, 1'b1, gap_cycles());
		sample_ch.valid <= 1'b0;
		settle();

		write_register(REG_SAMPLE_WIDTH, 32'd4);
		write_register(REG_VAD_THRESHOLD, 32'h8000_0000);
		send_sample(32'h8000_0000, 1'b1, gap_cycles());
		send_sample(32'h7FFF_FFFF, 1'b1, gap_cycles());
		// five full-scale squares saturate the sum
		for (int i = 0; i < 5; i++)
			send_sample(32'h8000_0000, i == 4, gap_cycles());
		send_sample(32'hFFFF_FFFF, 1'b0, gap_cycles());
		send_sample(32'h0000_0000, 1'b1, gap_cycles());
		sample_ch.valid <= 1'b0;
		settle();

		write_register(REG_SAMPLE_WIDTH, 32'd1);
		write_register(REG_VAD_THRESHOLD, 32'd0);
		send_sample(32'hFFFF_FF80, 1'b0, gap_cycles());
		send_sample(32'h0000_007F, 1'b0, gap_cycles());
		send_sample(32'h0000_0000, 1'b1, gap_cycles());
		sample_ch.valid <= 1'b0;
		settle();

		for (int p = 0; p < 8; p++) begin
			write_register(REG_SAMPLE_WIDTH, widths[p]);
			bits = 8 * meter_sb.sample_bytes_used();
			if (p == 1)
				thr = '0;
			else if (p == 3 || p == 6)
				thr = 32'h8000_0000;
			else
				thr = $urandom_range(0, 32'd1 << (bits - 1));
			write_register(REG_VAD_THRESHOLD, thr);
			idle_on = (p != 5);
			run_random_phase(175);
		end
		idle_on = 1'b1;

		while (meter_sb.outstanding() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (meter_sb.outstanding() != 0)
			meter_sb.report_mismatch("frame results never arrived");
		if (meter_sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/aflm_pkg.sv
hw/rtl/aflm_sample_if.sv
hw/rtl/aflm_result_if.sv
hw/rtl/aflm_cfg_if.sv
hw/rtl/aflm_ctrl.sv
hw/rtl/aflm_dp.sv
hw/rtl/audio_frame_level_meter_core.sv
test/tb_audio_frame_level_meter_core.sv
